// File: design/water_ripple_field_engine_assert.svh
// Assertion macros for the water ripple field engine.
`ifndef WATER_RIPPLE_FIELD_ENGINE_ASSERT_SVH
`define WATER_RIPPLE_FIELD_ENGINE_ASSERT_SVH

`ifndef ASSERT_OFF
`define WRFE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("water ripple field engine: implication failed");
`define WRFE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("water ripple field engine: forbidden condition");
`else
`define WRFE_ASSERT_IMPL(lbl, ante, cons)
`define WRFE_ASSERT_NEVER(lbl, cond)
`endif

`endif

// File: design/wrfe_pkg.sv
// Shared types, constants and helpers of the water ripple field engine.
`timescale 1ns / 1ps
package wrfe_pkg;

  localparam int ADDR_W = 16;
  localparam int CELLS  = 65536;

  typedef enum logic [2:0] {
    OP_STEP   = 3'd0,
    OP_RIPPLE = 3'd1,
    OP_BLOP   = 3'd2,
    OP_LOAD   = 3'd3,
    OP_SAMPLE = 3'd4
  } op_t;

  localparam logic [1:0] CFG_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_DAMPING = 2'd1;
  localparam logic [1:0] CFG_SHADE   = 2'd2;
  localparam logic [1:0] CFG_PALETTE = 2'd3;

  typedef struct packed {
    logic       effect_enable;
    logic [5:0] damping_factor;
    logic       shade_half;
    logic [7:0] palette_base;
  } cfg_t;

  // Height field access from the sequencer, in current/older terms.
  typedef struct packed {
    logic              cur_b;
    logic              clr;
    logic [ADDR_W-1:0] cur_ra0;
    logic [ADDR_W-1:0] cur_ra1;
    logic [ADDR_W-1:0] old_ra;
    logic              old_we;
    logic [ADDR_W-1:0] old_wa;
    logic [15:0]       old_wd;
  } fld_req_t;

  // Arithmetic shift right that truncates toward zero.
  function automatic logic signed [23:0] shr_trunc(input logic signed [23:0] v,
                                                   input logic [2:0] sh);
    logic signed [23:0] bias;
    bias = v[23] ? ((24'sd1 <<< sh) - 24'sd1) : 24'sd0;
    return (v + bias) >>> sh;
  endfunction

endpackage

// File: design/wrfe_ram.sv
// Generic single-write, dual-read synchronous RAM with registered reads.
`timescale 1ns / 1ps
module wrfe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra0,
  input  logic [$clog2(DEPTH)-1:0] ra1,
  output logic [WIDTH-1:0]         rd0,
  output logic [WIDTH-1:0]         rd1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

endmodule

// File: design/wrfe_shade.sv
// Shading of a sampled background index into a palette pixel.
`timescale 1ns / 1ps
module wrfe_shade import wrfe_pkg::*; (
  input  logic [7:0]         bg,
  input  logic signed [15:0] xo,
  input  cfg_t               cfg,
  output logic [7:0]         pixel
);

  logic signed [23:0] xq;
  logic signed [13:0] s;

  always_comb begin
    if (cfg.shade_half) begin
      xq = shr_trunc(24'(xo), 3'd6) + 24'sd4;
    end else begin
      xq = shr_trunc(24'(xo), 3'd5);
    end
    s = $signed({9'b0, bg[4:0]}) + $signed(xq[13:0]);
    if (s < 14'sd0) begin
      pixel = cfg.palette_base;
    end else if (s > 14'sd31) begin
      pixel = cfg.palette_base + 8'd31;
    end else begin
      pixel = cfg.palette_base + {3'b0, s[4:0]};
    end
  end

endmodule

// File: design/wrfe_seq.sv
// Operation sequencer with the step pipeline and field read-modify-write.
`timescale 1ns / 1ps
module wrfe_seq import wrfe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               operation,
  input  logic [7:0]               col,
  input  logic [7:0]               row,
  input  logic signed [15:0]       amount,
  input  logic [7:0]               span,
  input  logic [7:0]               background_value,
  input  cfg_t                     cfg,
  output fld_req_t                 req,
  input  logic [15:0]              cur_rd0,
  input  logic [15:0]              cur_rd1,
  input  logic [15:0]              old_rd,
  output logic                     bg_we,
  output logic [ADDR_W-1:0]        bg_wa,
  output logic [7:0]               bg_wd,
  output logic [ADDR_W-1:0]        bg_ra,
  input  logic [7:0]               bg_rd,
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic [7:0]               res_pixel,
  output logic signed [15:0]       res_x,
  output logic signed [15:0]       res_y
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_STEP, S_RIP_RD, S_RIP_WR, S_BLOP_RD, S_BLOP_WR,
    S_LOAD, S_SMP_LR, S_SMP_UD, S_SMP_BG, S_SMP_PIX, S_FINISH
  } state_t;

  state_t state;
  logic [15:0] cnt;
  logic        ph, issuing, cur_b;
  logic        s1_v, s2_v, s3_v, s4_v;
  logic [15:0] s1_a, s2_a, s3_a, s4_a;
  logic signed [16:0] lr;
  logic signed [15:0] oldv, vreg;
  logic signed [22:0] prod;
  logic [2:0]  rk;
  logic [7:0]  k, bcol;
  logic signed [12:0] ramp;
  logic signed [15:0] xo;
  logic [7:0]  l_col, l_row, l_span, l_bg;
  logic signed [15:0] l_amt;

  logic [7:0]  c, r;
  logic signed [17:0] sum;
  logic signed [23:0] half, qd, amt_half, xq, yq;
  logic signed [17:0] diff;
  logic signed [15:0] yo_now;
  logic [15:0] rip_addr;
  logic [15:0] rip_val;
  logic [7:0]  pix;

  assign c = cnt[7:0];
  assign r = cnt[15:8];
  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FINISH);

  wrfe_shade u_shade (
    .bg    (bg_rd),
    .xo    (xo),
    .cfg   (cfg),
    .pixel (pix)
  );

  always_comb begin
    sum  = 18'(lr) + 18'($signed(cur_rd0)) + 18'($signed(cur_rd1));
    half = shr_trunc(24'(sum), 3'd1);
    diff = half[17:0] - 18'(oldv);
    qd   = shr_trunc(24'(prod), 3'd5);
    amt_half = shr_trunc(24'(l_amt), 3'd1);
    yo_now = $signed(cur_rd0) - $signed(cur_rd1);
    xq = shr_trunc(24'(xo), 3'd5);
    yq = shr_trunc(24'(yo_now), 3'd5);
    rip_val = (rk == 3'd0) ? l_amt : amt_half[15:0];
    case (rk)
      3'd1:    rip_addr = {l_row, l_col - 8'd1};
      3'd2:    rip_addr = {l_row, l_col + 8'd1};
      3'd3:    rip_addr = {l_row + 8'd1, l_col};
      3'd4:    rip_addr = {l_row - 8'd1, l_col};
      default: rip_addr = {l_row, l_col};
    endcase
  end

  always_comb begin
    req = '0;
    req.cur_b = cur_b;
    bg_we = 1'b0;
    bg_wa = {l_row, l_col};
    bg_wd = l_bg;
    bg_ra = {l_row + yq[7:0], l_col + xq[7:0]};
    case (state)
      S_CLEAR: begin
        req.clr    = 1'b1;
        req.old_wa = cnt;
      end
      S_STEP: begin
        if (issuing) begin
          if (!ph) begin
            req.cur_ra0 = {r, c - 8'd1};
            req.cur_ra1 = {r, c + 8'd1};
            req.old_ra  = cnt;
          end else begin
            req.cur_ra0 = {r - 8'd1, c};
            req.cur_ra1 = {r + 8'd1, c};
          end
        end
        req.old_we = s4_v;
        req.old_wa = s4_a;
        req.old_wd = qd[15:0];
      end
      S_RIP_RD: req.old_ra = rip_addr;
      S_RIP_WR: begin
        req.old_we = 1'b1;
        req.old_wa = rip_addr;
        req.old_wd = old_rd + rip_val;
      end
      S_BLOP_RD: req.old_ra = {l_row, bcol};
      S_BLOP_WR: begin
        req.old_we = 1'b1;
        req.old_wa = {l_row, bcol};
        req.old_wd = old_rd + {{3{ramp[12]}}, ramp};
      end
      S_LOAD: bg_we = 1'b1;
      S_SMP_LR: begin
        req.cur_ra0 = {l_row, l_col - 8'd1};
        req.cur_ra1 = {l_row, l_col + 8'd1};
      end
      S_SMP_UD: begin
        req.cur_ra0 = {l_row - 8'd1, l_col};
        req.cur_ra1 = {l_row + 8'd1, l_col};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      ph      <= 1'b0;
      issuing <= 1'b0;
      cur_b   <= 1'b0;
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      s3_v    <= 1'b0;
      s4_v    <= 1'b0;
    end else begin
      // step pipeline: neighbor sums, damping product, write back
      s1_v <= (state == S_STEP) && issuing && !ph;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s1_a <= cnt;
      s2_a <= s1_a;
      s3_a <= s2_a;
      s4_a <= s3_a;
      if (s1_v) begin
        lr   <= 17'($signed(cur_rd0)) + 17'($signed(cur_rd1));
        oldv <= old_rd;
      end
      if (s2_v) begin
        vreg <= diff[15:0];
      end
      if (s3_v) begin
        prod <= vreg * $signed({1'b0, cfg.damping_factor});
      end

      case (state)
        S_CLEAR: begin
          cnt <= cnt + 16'd1;
          if (cnt == 16'hFFFF) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            l_col  <= col;
            l_row  <= row;
            l_amt  <= amount;
            l_span <= span;
            l_bg   <= background_value;
            bcol   <= col;
            res_pixel <= '0;
            res_x  <= '0;
            res_y  <= '0;
            rk     <= '0;
            k      <= '0;
            ramp   <= 13'sd1;
            cnt    <= '0;
            ph     <= 1'b0;
            case (operation)
              OP_STEP: begin
                if (cfg.effect_enable) begin
                  state   <= S_STEP;
                  issuing <= 1'b1;
                end else begin
                  state <= S_FINISH;
                end
              end
              OP_RIPPLE: state <= cfg.effect_enable ? S_RIP_RD : S_FINISH;
              OP_BLOP:   state <= cfg.effect_enable ? S_BLOP_RD : S_FINISH;
              OP_LOAD:   state <= S_LOAD;
              OP_SAMPLE: state <= S_SMP_LR;
              default:   state <= S_FINISH;
            endcase
          end
        end
        S_STEP: begin
          if (issuing) begin
            ph <= ~ph;
            if (ph) begin
              cnt <= cnt + 16'd1;
              if (cnt == 16'hFFFF) begin
                issuing <= 1'b0;
              end
            end
          end else if (!s1_v && !s2_v && !s3_v && !s4_v) begin
            cur_b <= ~cur_b;
            state <= S_FINISH;
          end
        end
        S_RIP_RD: state <= S_RIP_WR;
        S_RIP_WR: begin
          if (rk == 3'd4) begin
            state <= S_FINISH;
          end else begin
            rk    <= rk + 3'd1;
            state <= S_RIP_RD;
          end
        end
        S_BLOP_RD: state <= S_BLOP_WR;
        S_BLOP_WR: begin
          if (k < (l_span >> 1)) begin
            ramp <= ramp + 13'sd24;
          end else if (ramp > 13'sd1) begin
            ramp <= ramp - 13'sd24;
          end
          if (k == l_span) begin
            state <= S_FINISH;
          end else begin
            k     <= k + 8'd1;
            bcol  <= bcol + 8'd1;
            state <= S_BLOP_RD;
          end
        end
        S_LOAD: state <= S_FINISH;
        S_SMP_LR: state <= S_SMP_UD;
        S_SMP_UD: begin
          xo    <= $signed(cur_rd0) - $signed(cur_rd1);
          state <= S_SMP_BG;
        end
        S_SMP_BG: begin
          res_y <= yo_now;
          state <= S_SMP_PIX;
        end
        S_SMP_PIX: begin
          res_pixel <= pix;
          res_x     <= xo;
          state     <= S_FINISH;
        end
        S_FINISH: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/water_ripple_field_engine.sv
// Water ripple field engine top level: config, field memories, result register.
// Step: each cell's left/right, then up/down neighbours come from the current field.
// Ripple writes the centre cell and its four neighbours, blop span+1 row cells.
// One request at a time; a finished result waits in the output register.
// After reset a pass over all 65536 cells zeroes both height fields; no request is taken
// meanwhile. Configuration writes are taken at any time.
`timescale 1ns / 1ps
`include "water_ripple_field_engine_assert.svh"
module water_ripple_field_engine import wrfe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic [7:0]         col,
  input  logic [7:0]         row,
  input  logic signed [15:0] amount,
  input  logic [7:0]         span,
  input  logic [7:0]         background_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         pixel,
  output logic signed [15:0] x_offset,
  output logic signed [15:0] y_offset,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  cfg_t     cfg;
  fld_req_t req;
  logic [15:0] a_rd0, a_rd1, b_rd0, b_rd1;
  logic [15:0] cur_rd0, cur_rd1, old_rd;
  logic        a_we, b_we;
  logic        bg_we;
  logic [ADDR_W-1:0] bg_wa, bg_ra;
  logic [7:0]  bg_wd, bg_rd;
  logic        res_valid, res_ready;
  logic [7:0]  res_pixel;
  logic signed [15:0] res_x, res_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.effect_enable  <= 1'b1;
      cfg.damping_factor <= 6'd31;
      cfg.shade_half     <= 1'b0;
      cfg.palette_base   <= 8'd96;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:  cfg.effect_enable  <= cfg_data[0];
        CFG_DAMPING: cfg.damping_factor <= cfg_data[5:0];
        CFG_SHADE:   cfg.shade_half     <= cfg_data[0];
        CFG_PALETTE: cfg.palette_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  wrfe_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .col              (col),
    .row              (row),
    .amount           (amount),
    .span             (span),
    .background_value (background_value),
    .cfg              (cfg),
    .req              (req),
    .cur_rd0          (cur_rd0),
    .cur_rd1          (cur_rd1),
    .old_rd           (old_rd),
    .bg_we            (bg_we),
    .bg_wa            (bg_wa),
    .bg_wd            (bg_wd),
    .bg_ra            (bg_ra),
    .bg_rd            (bg_rd),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res_pixel        (res_pixel),
    .res_x            (res_x),
    .res_y            (res_y)
  );

  // route current/older roles onto the two physical fields
  assign a_we = req.clr | (req.old_we & req.cur_b);
  assign b_we = req.clr | (req.old_we & ~req.cur_b);
  assign cur_rd0 = req.cur_b ? b_rd0 : a_rd0;
  assign cur_rd1 = req.cur_b ? b_rd1 : a_rd1;
  assign old_rd  = req.cur_b ? a_rd0 : b_rd0;

  wrfe_ram #(.WIDTH(16), .DEPTH(CELLS)) u_field_a (
    .clk (clk),
    .we  (a_we),
    .wa  (req.old_wa),
    .wd  (req.old_wd),
    .ra0 (req.cur_b ? req.old_ra : req.cur_ra0),
    .ra1 (req.cur_ra1),
    .rd0 (a_rd0),
    .rd1 (a_rd1)
  );

  wrfe_ram #(.WIDTH(16), .DEPTH(CELLS)) u_field_b (
    .clk (clk),
    .we  (b_we),
    .wa  (req.old_wa),
    .wd  (req.old_wd),
    .ra0 (req.cur_b ? req.cur_ra0 : req.old_ra),
    .ra1 (req.cur_ra1),
    .rd0 (b_rd0),
    .rd1 (b_rd1)
  );

  wrfe_ram #(.WIDTH(8), .DEPTH(CELLS)) u_background (
    .clk (clk),
    .we  (bg_we),
    .wa  (bg_wa),
    .wd  (bg_wd),
    .ra0 (bg_ra),
    .ra1 (bg_ra),
    .rd0 (bg_rd),
    .rd1 ()
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
      if (res_valid) begin
        pixel    <= res_pixel;
        x_offset <= res_x;
        y_offset <= res_y;
      end
    end
  end

  `WRFE_ASSERT_NEVER(a_no_accept_in_clear, req.clr && in_ready)
  `WRFE_ASSERT_IMPL(a_idle_no_field_write, in_ready, !(a_we || b_we))
  `WRFE_ASSERT_IMPL(a_swap_ends_step, req.cur_b != $past(req.cur_b), res_valid)

endmodule
